>>> hdl/dcfd_pkg.sv
// ----------------------------------------------------------------------------
// dcfd_pkg
// Shared types, constants and helpers for the DCF77 time code decoder.
// ----------------------------------------------------------------------------
package dcfd_pkg;

    localparam int FRAME_BITS = 59;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int IDX_W      = $clog2(FRAME_BITS);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_W      = 16;

    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [7:0]  MINUTE_MAX = 8'd59;
    localparam logic [7:0]  HOUR_MAX   = 8'd23;
    localparam logic [7:0]  DAY_MAX    = 8'd31;
    localparam logic [7:0]  MONTH_MAX  = 8'd12;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE_MIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PULSE_MAX  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE_MAX = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_GAP_MIN  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_GAP_MAX  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_GAP_MIN  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_GAP_MAX  = 8'd7;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ZERO    = 3'd1,
        EV_ONE     = 3'd2,
        EV_SECOND  = 3'd3,
        EV_MINUTE  = 3'd4,
        EV_INVALID = 3'd5
    } event_t;

    typedef struct packed {
        logic        signal_level;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic        time_valid;
        logic [5:0]  minute_value;
        logic [4:0]  hour_value;
        logic [4:0]  day_value;
        logic [3:0]  month_value;
        logic [11:0] year_value;
        logic        sync_indicator;
        logic        error_indicator;
        logic        signal_indicator;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_pulse_min;
        logic [CFG_W-1:0] long_pulse_max;
        logic [CFG_W-1:0] short_pulse_min;
        logic [CFG_W-1:0] short_pulse_max;
        logic [CFG_W-1:0] minute_gap_min;
        logic [CFG_W-1:0] minute_gap_max;
        logic [CFG_W-1:0] second_gap_min;
        logic [CFG_W-1:0] second_gap_max;
    } cfg_t;

    typedef struct packed {
        event_t ev;
        logic   take_stamp;
    } class_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } frame_info_t;

    // Two BCD digits to binary; tens times ten is built from two shifts.
    function automatic logic [7:0] bcd_value(input logic [3:0] ones, input logic [3:0] tens);
        logic [7:0] t;
        t = {4'd0, tens};
        return {4'd0, ones} + (t << 3) + (t << 1);
    endfunction

endpackage

>>> hdl/dcfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dcfd_cfg_regs
// Timing window registers written through the configuration channel.
// ----------------------------------------------------------------------------
module dcfd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dcfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcfd_pkg::CFG_W-1:0]     cfg_data,
    output dcfd_pkg::cfg_t                 cfg
);
    import dcfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_PULSE_MIN:  cfg_next.long_pulse_min  = cfg_data;
                REG_LONG_PULSE_MAX:  cfg_next.long_pulse_max  = cfg_data;
                REG_SHORT_PULSE_MIN: cfg_next.short_pulse_min = cfg_data;
                REG_SHORT_PULSE_MAX: cfg_next.short_pulse_max = cfg_data;
                REG_MINUTE_GAP_MIN:  cfg_next.minute_gap_min  = cfg_data;
                REG_MINUTE_GAP_MAX:  cfg_next.minute_gap_max  = cfg_data;
                REG_SECOND_GAP_MIN:  cfg_next.second_gap_min  = cfg_data;
                REG_SECOND_GAP_MAX:  cfg_next.second_gap_max  = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_pulse_min  <= 16'd170;
            cfg_reg.long_pulse_max  <= 16'd230;
            cfg_reg.short_pulse_min <= 16'd70;
            cfg_reg.short_pulse_max <= 16'd130;
            cfg_reg.minute_gap_min  <= 16'd1900;
            cfg_reg.minute_gap_max  <= 16'd2100;
            cfg_reg.second_gap_min  <= 16'd900;
            cfg_reg.second_gap_max  <= 16'd1100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/dcfd_classify.sv
// ----------------------------------------------------------------------------
// dcfd_classify
// Times the current sample from the last falling edge and classifies it.
// ----------------------------------------------------------------------------
module dcfd_classify (
    input  logic              level,
    input  logic              prior_level,
    input  logic [31:0]       now_ms,
    input  logic [31:0]       last_fall,
    input  dcfd_pkg::cfg_t    cfg,
    output dcfd_pkg::class_t  cls
);
    import dcfd_pkg::*;

    logic [31:0] delta;

    // Stamps wrap, so the difference is taken modulo 2^32.
    assign delta = now_ms - last_fall;

    always_comb
    begin
        cls.ev         = EV_NONE;
        cls.take_stamp = 1'b0;
        if (level != prior_level)
        begin
            if (level)
            begin
                if (delta > {16'd0, cfg.long_pulse_max})
                    cls.ev = EV_INVALID;
                else if (delta >= {16'd0, cfg.long_pulse_min})
                    cls.ev = EV_ONE;
                else if (delta <= {16'd0, cfg.short_pulse_max} &&
                         delta >= {16'd0, cfg.short_pulse_min})
                    cls.ev = EV_ZERO;
                else
                    cls.ev = EV_INVALID;
            end
            else if (delta <= {16'd0, cfg.minute_gap_max})
            begin
                cls.take_stamp = 1'b1;
                if (delta >= {16'd0, cfg.minute_gap_min})
                    cls.ev = EV_MINUTE;
                else if (delta <= {16'd0, cfg.second_gap_max} &&
                         delta >= {16'd0, cfg.second_gap_min})
                    cls.ev = EV_SECOND;
                else
                    cls.ev = EV_INVALID;
            end
        end
        else if (delta >= {16'd0, cfg.minute_gap_max})
        begin
            cls.ev = EV_INVALID;
        end
    end

endmodule

>>> hdl/dcfd_frame_check.sv
// ----------------------------------------------------------------------------
// dcfd_frame_check
// Parity, start bit and range checks plus BCD decode of a complete frame.
// ----------------------------------------------------------------------------
module dcfd_frame_check (
    input  logic [dcfd_pkg::FRAME_BITS-1:0] frame,
    output dcfd_pkg::frame_info_t           info
);
    import dcfd_pkg::*;

    logic       parity_ok;
    logic [7:0] mi;
    logic [7:0] hr;
    logic [7:0] dy;
    logic [7:0] mo;
    logic [7:0] yr;

    assign parity_ok = ((^frame[27:21]) == frame[28]) &&
                       ((^frame[34:29]) == frame[35]) &&
                       ((^frame[57:36]) == frame[58]) &&
                       frame[20];

    assign mi = bcd_value(frame[24:21], {1'b0, frame[27:25]});
    assign hr = bcd_value(frame[32:29], {2'b00, frame[34:33]});
    assign dy = bcd_value(frame[39:36], {2'b00, frame[41:40]});
    assign mo = bcd_value(frame[48:45], {3'b000, frame[49]});
    assign yr = bcd_value(frame[53:50], frame[57:54]);

    // Ranges are checked on the full sums, before narrowing to the fields.
    assign info.ok     = parity_ok && (mi <= MINUTE_MAX) && (hr <= HOUR_MAX) &&
                         (dy <= DAY_MAX) && (mo <= MONTH_MAX);
    assign info.minute = mi[5:0];
    assign info.hour   = hr[4:0];
    assign info.day    = dy[4:0];
    assign info.month  = mo[3:0];
    assign info.year   = {4'd0, yr} + YEAR_BASE;

endmodule

>>> hdl/dcf77_time_code_decoder.sv
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder
// Decodes DCF77 pulses from level samples and millisecond stamps.
// Path: a request is held in the input register, then decoded into the output register.
// Throughput: one request per cycle unless out_ready stalls a full output.
// Reset: asynchronous, clears all control state and loads the default windows.
// ----------------------------------------------------------------------------
module dcf77_time_code_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dcfd_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dcfd_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dcfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcfd_pkg::CFG_W-1:0]     cfg_data
);
    import dcfd_pkg::*;

    cfg_t        cfg;
    class_t      cls;
    frame_info_t info;

    logic      in_full_reg;
    in_item_t  in_reg;
    logic      out_full_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      advance;

    logic                  prior_level_reg,  prior_level_next;
    logic [31:0]           last_fall_reg,    last_fall_next;
    logic [FRAME_BITS-1:0] frame_store_reg,  frame_store_next;
    logic [CNT_W-1:0]      bits_received_reg, bits_received_next;
    logic                  frame_open_reg,   frame_open_next;
    logic                  sync_flag_reg,    sync_flag_next;
    logic                  error_flag_reg,   error_flag_next;
    logic                  level_flag_reg,   level_flag_next;
    logic                  time_ok;

    dcfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcfd_classify u_class (
        .level       (in_reg.signal_level),
        .prior_level (prior_level_reg),
        .now_ms      (in_reg.now_ms),
        .last_fall   (last_fall_reg),
        .cfg         (cfg),
        .cls         (cls)
    );

    dcfd_frame_check u_check (
        .frame (frame_store_reg),
        .info  (info)
    );

    assign advance   = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign out_valid = out_full_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        prior_level_next   = in_reg.signal_level;
        last_fall_next     = cls.take_stamp ? in_reg.now_ms : last_fall_reg;
        frame_store_next   = frame_store_reg;
        bits_received_next = bits_received_reg;
        frame_open_next    = frame_open_reg;
        sync_flag_next     = sync_flag_reg;
        error_flag_next    = error_flag_reg;
        level_flag_next    = level_flag_reg;
        time_ok            = 1'b0;

        if (in_reg.signal_level != prior_level_reg)
            level_flag_next = !in_reg.signal_level;

        case (cls.ev)
            EV_INVALID:
            begin
                bits_received_next = '0;
                frame_open_next    = 1'b0;
                sync_flag_next     = 1'b0;
            end
            EV_ZERO, EV_ONE:
            begin
                // Bits before the first marker are dropped; an overfull frame is lost.
                if (frame_open_reg)
                begin
                    if (bits_received_reg < CNT_W'(FRAME_BITS))
                    begin
                        frame_store_next[bits_received_reg[IDX_W-1:0]] = (cls.ev == EV_ONE);
                        bits_received_next = bits_received_reg + CNT_W'(1);
                    end
                    else
                    begin
                        bits_received_next = '0;
                        frame_open_next    = 1'b0;
                        sync_flag_next     = 1'b0;
                    end
                end
            end
            EV_MINUTE:
            begin
                frame_open_next    = 1'b1;
                bits_received_next = '0;
                if (bits_received_reg >= CNT_W'(FRAME_BITS))
                begin
                    time_ok         = info.ok;
                    sync_flag_next  = info.ok;
                    error_flag_next = !info.ok;
                end
                else
                begin
                    sync_flag_next = 1'b0;
                end
            end
            default:
            begin
                frame_open_next = frame_open_reg;
            end
        endcase

        out_next.event_code       = cls.ev;
        out_next.time_valid       = time_ok;
        out_next.minute_value     = time_ok ? info.minute : 6'd0;
        out_next.hour_value       = time_ok ? info.hour   : 5'd0;
        out_next.day_value        = time_ok ? info.day    : 5'd0;
        out_next.month_value      = time_ok ? info.month  : 4'd0;
        out_next.year_value       = time_ok ? info.year   : 12'd0;
        out_next.sync_indicator   = sync_flag_next;
        out_next.error_indicator  = error_flag_next;
        out_next.signal_indicator = level_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            out_full_reg      <= 1'b0;
            prior_level_reg   <= 1'b0;
            last_fall_reg     <= '0;
            bits_received_reg <= '0;
            frame_open_reg    <= 1'b0;
            sync_flag_reg     <= 1'b0;
            error_flag_reg    <= 1'b0;
            level_flag_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_full_reg <= in_valid;
            if (advance)
                out_full_reg <= 1'b1;
            else if (out_ready)
                out_full_reg <= 1'b0;
            if (advance)
            begin
                prior_level_reg   <= prior_level_next;
                last_fall_reg     <= last_fall_next;
                bits_received_reg <= bits_received_next;
                frame_open_reg    <= frame_open_next;
                sync_flag_reg     <= sync_flag_next;
                error_flag_reg    <= error_flag_next;
                level_flag_reg    <= level_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (advance)
        begin
            out_reg         <= out_next;
            frame_store_reg <= frame_store_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_received_reg <= CNT_W'(FRAME_BITS))
        else $error("bit count beyond frame length");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> bits_received_reg == '0)
        else $error("bits counted while no frame is open");

    a_sync_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sync_flag_reg) |-> out_full_reg && out_reg.time_valid)
        else $error("sync set without a decoded frame");

    a_valid_on_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && out_reg.time_valid |-> out_reg.event_code == EV_MINUTE)
        else $error("time reported on a non-marker result");

    a_valid_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && out_reg.time_valid |->
            out_reg.sync_indicator && !out_reg.error_indicator)
        else $error("decoded frame with inconsistent indicators");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DCF77 time code decoder. Samples are sent as
// requests: a short directed run over the window boundaries, then random
// well-formed minute frames mixed with broken frames and loose noise, under
// the reset windows, the register extremes and random windows. Every request
// is predicted here and each result is compared in order with the prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcfd_pkg::*;

    localparam cfg_t DEFAULT_WINDOWS = {16'd170, 16'd230, 16'd70, 16'd130,
                                        16'd1900, 16'd2100, 16'd900, 16'd1100};
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd200;
    localparam int REPORT_LIMIT = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int sender_idle = 0;
    int receiver_idle = 0;
    int samples_sent = 0;
    int mismatches = 0;
    int results_seen = 0;

    out_item_t expected_results[$];

    // Decoder state as the bench tracks it.
    cfg_t                  windows;
    logic                  lvl_q;
    logic [31:0]           fall_stamp;
    logic [FRAME_BITS-1:0] frame_bits;
    int                    bit_count;
    logic                  in_frame;
    logic                  sync_q;
    logic                  err_q;
    logic                  sig_q;

    dcf77_time_code_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic void clear_decoder_state();
        windows = DEFAULT_WINDOWS;
        lvl_q = 1'b0;
        fall_stamp = '0;
        frame_bits = '0;
        bit_count = 0;
        in_frame = 1'b0;
        sync_q = 1'b0;
        err_q = 1'b0;
        sig_q = 1'b0;
    endfunction

    function automatic void drop_sync();
        bit_count = 0;
        in_frame = 1'b0;
        sync_q = 1'b0;
    endfunction

    function automatic void set_window(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] value);
        case (idx)
            REG_LONG_PULSE_MIN:  windows.long_pulse_min = value;
            REG_LONG_PULSE_MAX:  windows.long_pulse_max = value;
            REG_SHORT_PULSE_MIN: windows.short_pulse_min = value;
            REG_SHORT_PULSE_MAX: windows.short_pulse_max = value;
            REG_MINUTE_GAP_MIN:  windows.minute_gap_min = value;
            REG_MINUTE_GAP_MAX:  windows.minute_gap_max = value;
            REG_SECOND_GAP_MIN:  windows.second_gap_min = value;
            REG_SECOND_GAP_MAX:  windows.second_gap_max = value;
            default: ;
        endcase
    endfunction

    // BCD weights run 1, 2, 4, 8, 10, 20, 40, 80 from the first bit up.
    function automatic int field_sum(input int first, input int n);
        int s;
        s = 0;
        for (int i = 0; i < n; i++)
            if (frame_bits[first + i])
                s += (i < 4) ? (1 << i) : (10 << (i - 4));
        return s;
    endfunction

    function automatic out_item_t decode_sample(input in_item_t s);
        logic [31:0] delta;
        event_t      ev;
        out_item_t   r;
        logic        ok;
        int          mi, hr, dy, mo, yr;
        delta = s.now_ms - fall_stamp;
        ev = EV_NONE;
        r = '0;
        if (s.signal_level != lvl_q)
        begin
            if (s.signal_level)
            begin
                sig_q = 1'b0;
                if (delta > windows.long_pulse_max)
                    ev = EV_INVALID;
                else if (delta >= windows.long_pulse_min)
                    ev = EV_ONE;
                else if (delta <= windows.short_pulse_max && delta >= windows.short_pulse_min)
                    ev = EV_ZERO;
                else
                    ev = EV_INVALID;
            end
            else
            begin
                sig_q = 1'b1;
                // A gap beyond the stall limit leaves the stamp where it was.
                if (delta <= windows.minute_gap_max)
                begin
                    if (delta >= windows.minute_gap_min)
                        ev = EV_MINUTE;
                    else if (delta <= windows.second_gap_max &&
                             delta >= windows.second_gap_min)
                        ev = EV_SECOND;
                    else
                        ev = EV_INVALID;
                    fall_stamp = s.now_ms;
                end
            end
        end
        else if (delta >= windows.minute_gap_max)
        begin
            ev = EV_INVALID;
        end
        lvl_q = s.signal_level;

        case (ev)
            EV_INVALID: drop_sync();
            EV_ZERO, EV_ONE:
            begin
                if (in_frame)
                begin
                    if (bit_count < FRAME_BITS)
                    begin
                        frame_bits[bit_count] = (ev == EV_ONE);
                        bit_count++;
                    end
                    else
                    begin
                        drop_sync();
                    end
                end
            end
            EV_MINUTE:
            begin
                in_frame = 1'b1;
                if (bit_count >= FRAME_BITS)
                begin
                    ok = ((^frame_bits[27:21]) == frame_bits[28]) &&
                         ((^frame_bits[34:29]) == frame_bits[35]) &&
                         ((^frame_bits[57:36]) == frame_bits[58]) &&
                         frame_bits[20];
                    if (ok)
                    begin
                        mi = field_sum(21, 7);
                        hr = field_sum(29, 6);
                        dy = field_sum(36, 6);
                        mo = field_sum(45, 5);
                        yr = field_sum(50, 8) + YEAR_BASE;
                        ok = mi <= MINUTE_MAX && hr <= HOUR_MAX &&
                             dy <= DAY_MAX && mo <= MONTH_MAX;
                    end
                    if (ok)
                    begin
                        r.time_valid = 1'b1;
                        r.minute_value = mi[5:0];
                        r.hour_value = hr[4:0];
                        r.day_value = dy[4:0];
                        r.month_value = mo[3:0];
                        r.year_value = yr[11:0];
                        sync_q = 1'b1;
                        err_q = 1'b0;
                    end
                    else
                    begin
                        err_q = 1'b1;
                        sync_q = 1'b0;
                    end
                end
                else
                begin
                    sync_q = 1'b0;
                end
                bit_count = 0;
            end
            default: ;
        endcase

        r.event_code = ev;
        r.sync_indicator = sync_q;
        r.error_indicator = err_q;
        r.signal_indicator = sig_q;
        return r;
    endfunction

    function automatic string show_result(input out_item_t r);
        return $sformatf({"ev=%0d tv=%0d min=%0d hr=%0d day=%0d mon=%0d yr=%0d ",
                          "sync=%0d err=%0d sig=%0d"},
                         r.event_code, r.time_valid, r.minute_value, r.hour_value,
                         r.day_value, r.month_value, r.year_value, r.sync_indicator,
                         r.error_indicator, r.signal_indicator);
    endfunction

    // Spacing from the last accepted fall: wide, near the windows, or at a
    // window bound plus or minus one.
    function automatic logic [31:0] random_delta();
        logic [31:0] bound;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2500);
            2:
            begin
                case ($urandom_range(7))
                    0: bound = windows.long_pulse_min;
                    1: bound = windows.long_pulse_max;
                    2: bound = windows.short_pulse_min;
                    3: bound = windows.short_pulse_max;
                    4: bound = windows.minute_gap_min;
                    5: bound = windows.minute_gap_max;
                    6: bound = windows.second_gap_min;
                    default: bound = windows.second_gap_max;
                endcase
                return bound + $urandom_range(2) - 32'd1;
            end
            default: return $urandom_range(300);
        endcase
    endfunction

    function automatic logic [7:0] to_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic logic [FRAME_BITS-1:0] make_frame(input bit broken);
        logic [63:0]           raw;
        logic [FRAME_BITS-1:0] f;
        logic [7:0]            mi, hr, dy, mo, yr;
        int                    k;
        raw = {$urandom, $urandom};
        f = raw[FRAME_BITS-1:0];
        mi = to_bcd($urandom_range(59));
        hr = to_bcd($urandom_range(23));
        dy = to_bcd($urandom_range(31, 1));
        mo = to_bcd($urandom_range(12, 1));
        yr = to_bcd($urandom_range(99));
        if (broken)
        begin
            case ($urandom_range(2))
                0: mi = 8'($urandom);
                1: hr = 8'($urandom);
                default: mo = 8'($urandom);
            endcase
        end
        f[20] = 1'b1;
        f[27:21] = mi[6:0];
        f[28] = ^mi[6:0];
        f[34:29] = hr[5:0];
        f[35] = ^hr[5:0];
        f[41:36] = dy[5:0];
        f[44:42] = 3'($urandom_range(7, 1));
        f[49:45] = mo[4:0];
        f[57:50] = yr;
        f[58] = ^f[57:36];
        if (broken && $urandom_range(1))
        begin
            k = $urandom_range(FRAME_BITS - 1, 20);
            f[k] = ~f[k];
        end
        return f;
    endfunction

    task automatic send_sample(input logic level, input logic [31:0] stamp);
        in_item_t item;
        item.signal_level = level;
        item.now_ms = stamp;
        if (sender_idle != 0 && $urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(decode_sample(item));
        samples_sent++;
    endtask

    // Lets every pending result drain, plus the pipeline depth.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        set_window(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_windows(input cfg_t w);
        wait_idle();
        write_reg(REG_LONG_PULSE_MIN, w.long_pulse_min);
        write_reg(REG_LONG_PULSE_MAX, w.long_pulse_max);
        write_reg(REG_SHORT_PULSE_MIN, w.short_pulse_min);
        write_reg(REG_SHORT_PULSE_MAX, w.short_pulse_max);
        write_reg(REG_MINUTE_GAP_MIN, w.minute_gap_min);
        write_reg(REG_MINUTE_GAP_MAX, w.minute_gap_max);
        write_reg(REG_SECOND_GAP_MIN, w.second_gap_min);
        write_reg(REG_SECOND_GAP_MAX, w.second_gap_max);
    endtask

    // Brings the decoder to the state right after a minute marker.
    task automatic open_frame();
        if (!(in_frame && bit_count == 0 && lvl_q == 1'b0))
        begin
            if (lvl_q == 1'b0)
                send_sample(1'b1, fall_stamp + $urandom_range(windows.long_pulse_max));
            send_sample(1'b0, fall_stamp + $urandom_range(windows.minute_gap_max,
                                                          windows.minute_gap_min));
        end
    endtask

    // One pulse and one fall per bit; the last fall is the closing marker.
    task automatic send_frame(input logic [FRAME_BITS-1:0] bits, input int nbits,
                              input int glitch_at);
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] gap;
        logic        b;
        for (int i = 0; i < nbits; i++)
        begin
            t = fall_stamp;
            b = (i < FRAME_BITS) ? bits[i] : 1'($urandom_range(1));
            if (b)
                p = $urandom_range(windows.long_pulse_max, windows.long_pulse_min);
            else
                p = $urandom_range(windows.short_pulse_max, windows.short_pulse_min);
            if (i == glitch_at)
                p = random_delta();
            if (i == nbits - 1)
                gap = $urandom_range(windows.minute_gap_max, windows.minute_gap_min);
            else
                gap = $urandom_range(windows.second_gap_max, windows.second_gap_min);
            if (p > 0 && $urandom_range(3) == 0)
                send_sample(1'b0, t + $urandom_range(p - 1));
            send_sample(1'b1, t + p);
            if (gap > p + 1 && $urandom_range(3) == 0)
                send_sample(1'b1, t + $urandom_range(gap - 1, p + 1));
            send_sample(1'b0, t + gap);
        end
    endtask

    // Runs right after reset with the reset windows and a zero fall stamp.
    task automatic test_directed();
        send_sample(1'b0, 32'd0);           // no edge, no time elapsed
        send_sample(1'b0, 32'hFFFF_FFFF);   // stall from a huge spacing
        send_sample(1'b1, 32'd100);         // zero bit before any marker is ignored
        send_sample(1'b0, 32'd2000);        // marker with too few bits
        send_sample(1'b1, 32'd2200);        // one bit stored
        send_sample(1'b0, 32'd3000);        // plain second
        send_sample(1'b1, 32'd3230);        // one bit at the upper pulse bound
        send_sample(1'b0, 32'd3900);        // second at the lower gap bound
        send_sample(1'b1, 32'd4131);        // pulse just too long
        send_sample(1'b0, 32'd5000);        // second at the upper gap bound
        send_sample(1'b1, 32'd5069);        // pulse just too short
        send_sample(1'b0, 32'd6101);        // gap between second and minute windows
        send_sample(1'b1, 32'd6232);        // pulse between the two pulse windows
        send_sample(1'b0, 32'd8202);        // gap past the stall limit keeps the stamp
        send_sample(1'b0, 32'd8201);        // no edge at exactly the stall limit
        send_sample(1'b1, 32'd8100);
        send_sample(1'b0, 32'd8001);        // marker at the lower minute bound
        send_sample(1'b1, 32'd8071);        // zero bit at the lower short bound
        send_sample(1'b1, 32'd10100);       // no edge just below the stall limit
        send_sample(1'b0, 32'd10101);       // marker at the upper minute bound
        send_sample(1'b1, 32'd10231);       // zero bit at the upper short bound
        send_sample(1'b1, 32'hFFFF_FFFF);   // stall while high
        send_sample(1'b0, 32'd10271);
    endtask

    task automatic test_frames(input int target);
        int stop_at;
        int kind;
        int nbits;
        int glitch_at;
        stop_at = samples_sent + target;
        while (samples_sent < stop_at)
        begin
            kind = $urandom_range(9);
            nbits = FRAME_BITS;
            glitch_at = -1;
            if (kind == 7)
                nbits = $urandom_range(FRAME_BITS - 1, 1);
            else if (kind == 8)
                nbits = FRAME_BITS + 1;
            else if (kind == 9)
                glitch_at = $urandom_range(FRAME_BITS - 1);
            open_frame();
            send_frame(make_frame(kind == 6), nbits, glitch_at);
        end
    endtask

    task automatic test_noise(input int n);
        repeat (n)
            send_sample(1'($urandom_range(1)), fall_stamp + random_delta());
    endtask

    task automatic test_register_extremes();
        cfg_t w;
        load_windows('0);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        test_noise(30);
        load_windows('1);
        write_reg(REG_UNMAPPED, 16'h0000);
        test_noise(30);
        // Random windows, overlapping or inverted as they fall.
        w = {$urandom, $urandom, $urandom, $urandom};
        load_windows(w);
        test_noise(30);
        load_windows(DEFAULT_WINDOWS);
    endtask

    task automatic test_changed_windows();
        cfg_t w;
        w.long_pulse_min = $urandom_range(200, 150);
        w.long_pulse_max = w.long_pulse_min + $urandom_range(60);
        w.short_pulse_min = $urandom_range(80, 20);
        w.short_pulse_max = $urandom_range(140, w.short_pulse_min);
        w.second_gap_min = $urandom_range(1000, 600);
        w.second_gap_max = w.second_gap_min + $urandom_range(300);
        w.minute_gap_min = $urandom_range(2000, 1500);
        w.minute_gap_max = w.minute_gap_min + $urandom_range(500);
        load_windows(w);
        test_frames(150);
        test_noise(60);
        load_windows(DEFAULT_WINDOWS);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_idle);

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: %s",
                             results_seen, show_result(out_data));
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.event_code       !== want.event_code ||
                    out_data.time_valid       !== want.time_valid ||
                    out_data.minute_value     !== want.minute_value ||
                    out_data.hour_value       !== want.hour_value ||
                    out_data.day_value        !== want.day_value ||
                    out_data.month_value      !== want.month_value ||
                    out_data.year_value       !== want.year_value ||
                    out_data.sync_indicator   !== want.sync_indicator ||
                    out_data.error_indicator  !== want.error_indicator ||
                    out_data.signal_indicator !== want.signal_indicator)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d mismatch: expected %s, got %s",
                                 results_seen, show_result(want), show_result(out_data));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        clear_decoder_state();
        sender_idle = 27;
        receiver_idle = 58;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_frames(180);
        test_noise(80);
        test_register_extremes();

        sender_idle = 58;
        receiver_idle = 27;
        test_changed_windows();
        test_noise(40);

        sender_idle = 0;
        receiver_idle = 0;
        test_frames(180);
        test_noise(80);

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
